// ===== design/bpa_pkg.sv =====
// shared types and constants for the buddy page allocator
`timescale 1ns / 1ps

package bpa_pkg;

   localparam int MAX_PAGES   = 4096;
   localparam int ORDER_COUNT = 11;
   localparam int PAGE_W      = 12;
   localparam int ORDER_W     = 4;
   localparam int COUNT_W     = 13;
   localparam int AVAIL_W     = 17;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   typedef logic [PAGE_W-1:0]  page_type;
   typedef logic [ORDER_W-1:0] order_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [AVAIL_W-1:0] avail_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOMEM   = 2'd1,
      STATUS_BADFREE = 2'd2
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   localparam count_type ZONE_RESET = count_type'(MAX_PAGES);
   localparam logic      REG_ZONE   = 1'b0;

   typedef struct packed {
      logic      opcode;
      order_type block_order;
      page_type  page_number;
   } req_payload_type;

   typedef struct packed {
      status_type status;
      page_type   granted_page;
      count_type  free_page_total;
   } rsp_payload_type;

endpackage

// ===== design/bpa_chan_if.sv =====
// request and response channel interfaces of the buddy page allocator
`timescale 1ns / 1ps

interface bpa_req_if;
   import bpa_pkg::*;
   logic      valid;
   logic      ready;
   logic      opcode;
   order_type block_order;
   page_type  page_number;
   modport source (output valid, output opcode, output block_order, output page_number,
                   input ready);
   modport sink (input valid, input opcode, input block_order, input page_number,
                 output ready);
endinterface

interface bpa_rsp_if;
   import bpa_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   page_type   granted_page;
   count_type  free_page_total;
   modport source (output valid, output status, output granted_page,
                   output free_page_total, input ready);
   modport sink (input valid, input status, input granted_page, input free_page_total,
                 output ready);
endinterface

// ===== design/bpa_csr.sv =====
// apb register block holding the zone size
`timescale 1ns / 1ps

module bpa_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bpa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bpa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output bpa_pkg::count_type               zone_o
);
   import bpa_pkg::*;

   count_type zone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= ZONE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[CSR_ADDR_W-1] == REG_ZONE) begin
         zone_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DATA_W'(zone_ff);
   assign zone_o     = zone_ff;

endmodule

// ===== design/bpa_engine.sv =====
// sequencer, free-list registers and page memories of the buddy allocator
`timescale 1ns / 1ps

module bpa_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  bpa_pkg::count_type        zone_i,
   input  logic                      req_valid_i,
   output logic                      req_ready_o,
   input  bpa_pkg::req_payload_type  req_i,
   output logic                      rsp_valid_o,
   input  logic                      rsp_ready_i,
   output bpa_pkg::rsp_payload_type  rsp_o
);
   import bpa_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_A_SCAN, S_A_TAKE, S_A_AFTER, S_A_PUSHB,
      S_F_RD, S_F_CHK, S_F_BRD, S_F_BCHK, S_F_UNB, S_F_MERGE,
      S_U_RD, S_U_WR, S_RESP
   } state_type;

   state_type  state_ff, ret_ff;
   page_type   clr_ff, cur_ff, ux_ff;
   order_type  ord_ff, want_ff;
   avail_type  avail_ff;
   status_type status_ff;
   page_type   granted_ff;
   logic       rsp_valid_ff;

   page_type                 head_ff [ORDER_COUNT];
   page_type                 tail_ff [ORDER_COUNT];
   logic [ORDER_COUNT-1:0]   nonempty_ff;

   // page memories
   logic      mark_mem  [MAX_PAGES];
   order_type order_mem [MAX_PAGES];
   page_type  next_mem  [MAX_PAGES];
   page_type  prev_mem  [MAX_PAGES];

   logic      rd_mark_ff;
   order_type rd_ord_ff;
   page_type  rd_next_ff, rd_prev_ff;

   logic      mark_we, mark_wd, ord_we, next_we, prev_we, push_en;
   page_type  mark_wa, ord_wa, next_wa, next_wd, prev_wa, prev_wd, attr_ra, push_x;
   order_type ord_wd, push_lv;

   page_type  bit_ord, bit_dn, bud, bud_dn, nidx;
   count_type limit;
   logic      free_ok, bud_ok;
   avail_type size_want;

   // shared shift / xor unit for buddy and size arithmetic
   always_comb begin
      bit_ord   = page_type'(1) << ord_ff;
      bit_dn    = page_type'(1) << (ord_ff - order_type'(1));
      bud       = cur_ff ^ bit_ord;
      bud_dn    = cur_ff ^ bit_dn;
      nidx      = cur_ff & ~(page_type'(bit_ord << 1) - page_type'(1));
      limit     = (zone_i > count_type'(MAX_PAGES)) ? count_type'(MAX_PAGES) : zone_i;
      size_want = avail_type'(1) << want_ff;
      free_ok   = rd_mark_ff && (rd_ord_ff < order_type'(ORDER_COUNT)) &&
                  ((avail_type'(cur_ff) + (avail_type'(1) << rd_ord_ff)) <=
                   avail_type'(limit));
      bud_ok    = (ord_ff < order_type'(ORDER_COUNT - 1)) &&
                  ((avail_type'(bud) + (avail_type'(1) << ord_ff)) <= avail_type'(limit));
   end

   always_comb begin
      mark_we = 1'b0;  mark_wa = cur_ff;  mark_wd = 1'b0;
      ord_we  = 1'b0;  ord_wa  = cur_ff;  ord_wd  = ord_ff;
      next_we = 1'b0;  next_wa = cur_ff;  next_wd = cur_ff;
      prev_we = 1'b0;  prev_wa = cur_ff;  prev_wd = cur_ff;
      push_en = 1'b0;  push_lv = ord_ff;  push_x  = cur_ff;
      attr_ra = cur_ff;
      unique case (state_ff)
         S_CLEAR: begin
            mark_we = 1'b1;  mark_wa = clr_ff;  mark_wd = 1'b1;
            ord_we  = 1'b1;  ord_wa  = clr_ff;  ord_wd  = '0;
         end
         S_F_CHK: begin
            if (free_ok) begin
               mark_we = 1'b1;
               push_en = 1'b1;
               push_lv = rd_ord_ff;
            end
         end
         S_F_BRD: attr_ra = bud;
         S_A_AFTER: begin
            if (ord_ff == want_ff) begin
               mark_we = 1'b1;
               mark_wd = 1'b1;
            end else begin
               push_en = 1'b1;
               push_lv = ord_ff - order_type'(1);
               ord_we  = 1'b1;
               ord_wd  = ord_ff - order_type'(1);
            end
         end
         S_A_PUSHB: begin
            push_en = 1'b1;
            push_lv = ord_ff - order_type'(1);
            push_x  = bud_dn;
            ord_we  = 1'b1;
            ord_wa  = bud_dn;
            ord_wd  = ord_ff - order_type'(1);
         end
         S_F_MERGE: begin
            push_en = 1'b1;
            push_lv = ord_ff + order_type'(1);
            push_x  = nidx;
            ord_we  = 1'b1;
            ord_wa  = nidx;
            ord_wd  = ord_ff + order_type'(1);
         end
         S_U_WR: begin
            if (!(head_ff[ord_ff] == ux_ff && tail_ff[ord_ff] == ux_ff)) begin
               if (head_ff[ord_ff] != ux_ff) begin
                  next_we = 1'b1;  next_wa = rd_prev_ff;  next_wd = rd_next_ff;
               end
               if (tail_ff[ord_ff] != ux_ff) begin
                  prev_we = 1'b1;  prev_wa = rd_next_ff;  prev_wd = rd_prev_ff;
               end
            end
         end
         S_IDLE, S_A_SCAN, S_A_TAKE, S_F_RD, S_F_BCHK, S_F_UNB, S_U_RD, S_RESP: begin
         end
      endcase
      // append to tail links when the list already holds entries
      if (push_en && nonempty_ff[push_lv]) begin
         next_we = 1'b1;  next_wa = tail_ff[push_lv];  next_wd = push_x;
         prev_we = 1'b1;  prev_wa = push_x;            prev_wd = tail_ff[push_lv];
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      rd_mark_ff <= mark_mem[attr_ra];
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         order_mem[ord_wa] <= ord_wd;
      end
      rd_ord_ff <= order_mem[attr_ra];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      rd_next_ff <= next_mem[ux_ff];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      rd_prev_ff <= prev_mem[ux_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ret_ff       <= S_IDLE;
         clr_ff       <= '0;
         nonempty_ff  <= '0;
         avail_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (push_en) begin
            if (!nonempty_ff[push_lv]) begin
               head_ff[push_lv]     <= push_x;
               nonempty_ff[push_lv] <= 1'b1;
            end
            tail_ff[push_lv] <= push_x;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + page_type'(1);
               if (clr_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid_i) begin
                  cur_ff  <= req_i.page_number;
                  ord_ff  <= req_i.block_order;
                  want_ff <= req_i.block_order;
                  if (req_i.opcode == OP_FREE) begin
                     state_ff <= S_F_RD;
                  end else if (req_i.block_order >= order_type'(ORDER_COUNT)) begin
                     status_ff    <= STATUS_NOMEM;
                     granted_ff   <= '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_RESP;
                  end else begin
                     state_ff <= S_A_SCAN;
                  end
               end
            end
            S_A_SCAN: begin
               if (nonempty_ff[ord_ff]) begin
                  state_ff <= S_A_TAKE;
               end else if (ord_ff == order_type'(ORDER_COUNT - 1)) begin
                  status_ff    <= STATUS_NOMEM;
                  granted_ff   <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end else begin
                  ord_ff <= ord_ff + order_type'(1);
               end
            end
            S_A_TAKE: begin
               if (!nonempty_ff[ord_ff]) begin
                  status_ff    <= STATUS_NOMEM;
                  granted_ff   <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end else begin
                  cur_ff   <= head_ff[ord_ff];
                  ux_ff    <= head_ff[ord_ff];
                  ret_ff   <= S_A_AFTER;
                  state_ff <= S_U_RD;
               end
            end
            S_A_AFTER: begin
               if (ord_ff == want_ff) begin
                  avail_ff     <= (avail_ff >= size_want) ? avail_ff - size_want : '0;
                  status_ff    <= STATUS_OK;
                  granted_ff   <= cur_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end else begin
                  state_ff <= S_A_PUSHB;
               end
            end
            S_A_PUSHB: begin
               ord_ff   <= ord_ff - order_type'(1);
               state_ff <= S_A_TAKE;
            end
            S_F_RD: state_ff <= S_F_CHK;
            S_F_CHK: begin
               if (free_ok) begin
                  avail_ff <= avail_ff + (avail_type'(1) << rd_ord_ff);
                  ord_ff   <= rd_ord_ff;
                  state_ff <= S_F_BRD;
               end else begin
                  status_ff    <= STATUS_BADFREE;
                  granted_ff   <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end
            end
            S_F_BRD: begin
               if (bud_ok) begin
                  state_ff <= S_F_BCHK;
               end else begin
                  status_ff    <= STATUS_OK;
                  granted_ff   <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end
            end
            S_F_BCHK: begin
               if (rd_mark_ff || rd_ord_ff != ord_ff) begin
                  status_ff    <= STATUS_OK;
                  granted_ff   <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end else begin
                  ux_ff    <= cur_ff;
                  ret_ff   <= S_F_UNB;
                  state_ff <= S_U_RD;
               end
            end
            S_F_UNB: begin
               ux_ff    <= bud;
               ret_ff   <= S_F_MERGE;
               state_ff <= S_U_RD;
            end
            S_F_MERGE: begin
               ord_ff   <= ord_ff + order_type'(1);
               cur_ff   <= nidx;
               state_ff <= S_F_BRD;
            end
            S_U_RD: begin
               // empty list: nothing to unlink
               state_ff <= nonempty_ff[ord_ff] ? S_U_WR : ret_ff;
            end
            S_U_WR: begin
               if (head_ff[ord_ff] == ux_ff && tail_ff[ord_ff] == ux_ff) begin
                  nonempty_ff[ord_ff] <= 1'b0;
               end else begin
                  if (head_ff[ord_ff] == ux_ff) begin
                     head_ff[ord_ff] <= rd_next_ff;
                  end
                  if (tail_ff[ord_ff] == ux_ff) begin
                     tail_ff[ord_ff] <= rd_prev_ff;
                  end
               end
               state_ff <= ret_ff;
            end
            S_RESP: begin
               if (rsp_ready_i) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign req_ready_o           = (state_ff == S_IDLE);
   assign rsp_valid_o           = rsp_valid_ff;
   assign rsp_o.status          = status_ff;
   assign rsp_o.granted_page    = granted_ff;
   assign rsp_o.free_page_total = avail_ff[COUNT_W-1:0];

`ifndef ASSERT_OFF
   a_ready_drops: assert property (@(posedge clock) disable iff (reset)
      (req_valid_i && req_ready_o) |=> !req_ready_o)
      else $error("request accepted while engine busy");

   a_fail_no_page: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_o && rsp_o.status != STATUS_OK) |-> rsp_o.granted_page == '0)
      else $error("failed request returns a page");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push_en |=> nonempty_ff[$past(push_lv)])
      else $error("free list empty after append");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!push_en && !next_we && !prev_we && !rsp_valid_o))
      else $error("list activity during clearing pass");
`endif

endmodule

// ===== design/buddy_page_allocator.sv =====
// Binary buddy page allocator over one zone of pages.
// Request channel (req_chan): opcode 0 allocates a block of 2^block_order pages,
// opcode 1 frees the block whose head page is page_number. Response channel
// (rsp_chan): one response per request with status (ok, no memory, invalid
// free), granted_page and free_page_total after the request.
// Config: APB register at byte 0 holds zone_page_count (pages 0..count-1).
// Allocate scans upward from the requested order to the first non-empty list,
// unlinks its head block and splits it down one level at a time; an order too
// large answers without a scan. Free checks the block, then merges it with its
// buddy level by level while that buddy is free. Req ready returns in the cycle
// after the response is taken, so one request at a time, paced by the page
// memories and the one shift/xor unit.
// Reset: a clearing pass marks every page allocated at order 0;
// no request is taken meanwhile, config writes are taken as ever. All lists
// are empty, so software frees each page to fill them.
// Stall: a response waits in its register until rsp ready; the next request is
// taken only after that.
`timescale 1ns / 1ps

module buddy_page_allocator (
   input  logic                            clock,
   input  logic                            reset,
   bpa_req_if.sink                         req_chan,
   bpa_rsp_if.source                       rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bpa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bpa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import bpa_pkg::*;

   count_type       zone;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;

   assign req_payload.opcode      = req_chan.opcode;
   assign req_payload.block_order = req_chan.block_order;
   assign req_payload.page_number = req_chan.page_number;

   bpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .zone_o      (zone)
   );

   bpa_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .zone_i      (zone),
      .req_valid_i (req_chan.valid),
      .req_ready_o (req_chan.ready),
      .req_i       (req_payload),
      .rsp_valid_o (rsp_chan.valid),
      .rsp_ready_i (rsp_chan.ready),
      .rsp_o       (rsp_payload)
   );

   assign rsp_chan.status          = rsp_payload.status;
   assign rsp_chan.granted_page    = rsp_payload.granted_page;
   assign rsp_chan.free_page_total = rsp_payload.free_page_total;

endmodule
